// File: rtl/prim_asm_pkg.sv
package prim_asm_pkg;

  localparam logic [2:0] MODE_LINES = 3'd0;
  localparam logic [2:0] MODE_TRIS  = 3'd1;
  localparam logic [2:0] MODE_STRIP = 3'd2;
  localparam logic [2:0] MODE_LOOP  = 3'd3;
  localparam logic [2:0] MODE_QUADS = 3'd4;

  localparam logic PRIM_LINES = 1'b0;
  localparam logic PRIM_TRIS  = 1'b1;

  localparam int unsigned QUAD_HELD = 3;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_STRIP,
    KIND_LOOP,
    KIND_QUAD
  } kind_e;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    logic [31:0] a;
  } vertex_t;

  typedef struct packed {
    kind_e         kind;
    logic          prim;
    vertex_t [3:0] slots;
  } cmd_t;

  function automatic logic [2:0] cmd_len(input kind_e kind);
    logic [2:0] len;
    unique case (kind)
      KIND_PASS:  len = 3'd1;
      KIND_STRIP: len = 3'd2;
      KIND_LOOP:  len = 3'd4;
      KIND_QUAD:  len = 3'd6;
      default:    len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] cmd_slot(input kind_e kind, input logic [2:0] idx);
    logic [1:0] sel;
    sel = 2'd0;
    unique case (kind)
      KIND_PASS:  sel = 2'd0;
      KIND_STRIP: sel = idx[0] ? 2'd1 : 2'd0;
      KIND_LOOP: begin
        unique case (idx)
          3'd0:    sel = 2'd0;
          3'd1:    sel = 2'd1;
          3'd2:    sel = 2'd1;
          3'd3:    sel = 2'd2;
          default: sel = 2'd0;
        endcase
      end
      KIND_QUAD: begin
        unique case (idx)
          3'd0:    sel = 2'd0;
          3'd1:    sel = 2'd1;
          3'd2:    sel = 2'd2;
          3'd3:    sel = 2'd0;
          3'd4:    sel = 2'd2;
          3'd5:    sel = 2'd3;
          default: sel = 2'd0;
        endcase
      end
      default: sel = 2'd0;
    endcase
    return sel;
  endfunction

endpackage

// File: rtl/prim_asm_front.sv
module prim_asm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [2:0]            mode_i,
  input  prim_asm_pkg::vertex_t cur_i,
  input  logic                  prim_end_i,
  output logic                  push_o,
  output prim_asm_pkg::cmd_t    cmd_o
);
  import prim_asm_pkg::*;

  vertex_t                 prev_q, prev_d;
  vertex_t                 first_q, first_d;
  vertex_t [QUAD_HELD-1:0] quad_hold_q, quad_hold_d;
  logic [1:0]              quad_phase_q, quad_phase_d;
  logic                    seen_q, seen_d;
  logic                    emit;

  always_comb begin
    emit         = 1'b0;
    cmd_o.kind   = KIND_PASS;
    cmd_o.prim   = PRIM_LINES;
    cmd_o.slots  = {4{cur_i}};
    prev_d       = prev_q;
    first_d      = first_q;
    quad_hold_d  = quad_hold_q;
    quad_phase_d = quad_phase_q;
    seen_d       = seen_q;
    unique case (mode_i)
      MODE_LINES, MODE_TRIS: begin
        emit       = 1'b1;
        cmd_o.prim = mode_i[0];
      end
      MODE_STRIP, MODE_LOOP: begin
        if (seen_q) begin
          emit           = 1'b1;
          cmd_o.kind     = (mode_i == MODE_LOOP && prim_end_i) ? KIND_LOOP : KIND_STRIP;
          cmd_o.slots[0] = prev_q;
          cmd_o.slots[1] = cur_i;
          cmd_o.slots[2] = first_q;
        end else begin
          first_d = cur_i;
        end
        prev_d = cur_i;
        seen_d = 1'b1;
      end
      MODE_QUADS: begin
        if (quad_phase_q == 2'd3) begin
          emit           = 1'b1;
          cmd_o.kind     = KIND_QUAD;
          cmd_o.prim     = PRIM_TRIS;
          cmd_o.slots[0] = quad_hold_q[0];
          cmd_o.slots[1] = quad_hold_q[1];
          cmd_o.slots[2] = quad_hold_q[2];
          cmd_o.slots[3] = cur_i;
          quad_phase_d   = 2'd0;
        end else begin
          quad_hold_d[quad_phase_q] = cur_i;
          quad_phase_d              = quad_phase_q + 2'd1;
        end
      end
      default: ;
    endcase
    if (prim_end_i) begin
      seen_d       = 1'b0;
      quad_phase_d = 2'd0;
    end
    push_o = accept_i && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_phase_q <= 2'd0;
      seen_q       <= 1'b0;
    end else if (accept_i) begin
      quad_phase_q <= quad_phase_d;
      seen_q       <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      prev_q      <= prev_d;
      first_q     <= first_d;
      quad_hold_q <= quad_hold_d;
    end
  end

endmodule

// File: rtl/prim_asm_queue.sv
module prim_asm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  prim_asm_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output prim_asm_pkg::cmd_t head_o
);
  import prim_asm_pkg::*;

  cmd_t [1:0] mem_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  always_comb begin
    full_o   = (count_q == 2'd2);
    valid_o  = (count_q != 2'd0);
    head_o   = mem_q[rd_ptr_q];
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/prim_asm_back.sv
module prim_asm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  prim_asm_pkg::cmd_t    head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_prim_o,
  output prim_asm_pkg::vertex_t out_vtx_o,
  output logic                  out_last_o
);
  import prim_asm_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic       prim_q;
  vertex_t    vtx_q;
  logic       last_q;
  logic       advance;
  logic       load;
  logic       is_last;

  always_comb begin
    advance = !valid_q || !out_stall_i;
    load    = advance && head_valid_i;
    is_last = (idx_q == cmd_len(head_i.kind) - 3'd1);
    pop_o   = load && is_last;
    valid_d = advance ? head_valid_i : valid_q;
    idx_d   = idx_q;
    if (load) begin
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prim_q <= head_i.prim;
      vtx_q  <= head_i.slots[cmd_slot(head_i.kind, idx_q)];
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_prim_o  = prim_q;
  assign out_vtx_o   = vtx_q;
  assign out_last_o  = last_q;

endmodule

// File: rtl/primitive_assembler_lines_tris_top.sv
// Each result passes through the command queue and the sequencer's output register.
// Throughput: one result per cycle while out_stall_i is low; one vertex per cycle while
// each vertex gives at most one result, else bounded by the output (six results per quad).
// A two-entry command queue between the vertex front end and the output sequencer.
// Reset clears the queue, the sequencer and the strip/quad progress; held vertices are not.
module primitive_assembler_lines_tris_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] col_r_i,
  input  logic [31:0] col_g_i,
  input  logic [31:0] col_b_i,
  input  logic [31:0] col_a_i,
  input  logic        prim_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_prim_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [31:0] out_r_o,
  output logic [31:0] out_g_o,
  output logic [31:0] out_b_o,
  output logic [31:0] out_a_o,
  output logic        out_last_o
);
  import prim_asm_pkg::*;

  vertex_t cur;
  vertex_t out_vtx;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    accept;
  logic    push;
  logic    full;
  logic    head_valid;
  logic    pop;

  assign cur.x = pos_x_i;
  assign cur.y = pos_y_i;
  assign cur.z = pos_z_i;
  assign cur.r = col_r_i;
  assign cur.g = col_g_i;
  assign cur.b = col_b_i;
  assign cur.a = col_a_i;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  prim_asm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .mode_i     (mode_i),
    .cur_i      (cur),
    .prim_end_i (prim_end_i),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  prim_asm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  prim_asm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_prim_o   (out_prim_o),
    .out_vtx_o    (out_vtx),
    .out_last_o   (out_last_o)
  );

  assign out_x_o = out_vtx.x;
  assign out_y_o = out_vtx.y;
  assign out_z_o = out_vtx.z;
  assign out_r_o = out_vtx.r;
  assign out_g_o = out_vtx.g;
  assign out_b_o = out_vtx.b;
  assign out_a_o = out_vtx.a;

endmodule
